// ===== design/joystick_dead_zone_filter_assert.svh =====
// Assertion macros shared by the checker of the joystick dead-zone filter.
`ifndef JOYSTICK_DEAD_ZONE_FILTER_ASSERT_SVH
`define JOYSTICK_DEAD_ZONE_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled in reset.
`define JDZ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("joystick dead-zone filter check failed");

// Next-cycle implication, sampled on aclk and disabled in reset.
`define JDZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("joystick dead-zone filter check failed");

`endif

// ===== design/jdz_pkg.sv =====
// ----------------------------------------------------------------------------
// jdz_pkg
// Widths, constants, shared types and the output encoder of the
// joystick dead-zone filter.
// ----------------------------------------------------------------------------
package jdz_pkg;

    localparam int AXIS_BITS     = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int CFG_W         = 15;
    localparam int CIDX_W        = 2;
    localparam int MAG_W         = AXIS_BITS;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int LEN_FRAC      = 8;
    localparam int RAD_W         = SQ_W + 2 * LEN_FRAC;
    localparam int LEN_W         = RAD_W / 2;
    localparam int REM_W         = LEN_W + 3;
    localparam int Q_W           = OUT_FRAC_BITS + 1;
    localparam int FQ_STEPS      = OUT_FRAC_BITS;
    localparam int PROD_W        = MAG_W + Q_W;
    localparam int NUM_W         = PROD_W + LEN_FRAC;

    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {OUT_FRAC_BITS{1'b1}}};

    localparam logic [CIDX_W-1:0] CFG_DZ_AXIS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DZ_STICK   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FULL_SCALE = 2'd2;

    localparam logic [CFG_W-1:0] DZ_AXIS_RST    = 15'd250;
    localparam logic [CFG_W-1:0] DZ_STICK_RST   = 15'd8000;
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 15'd30000;

    typedef struct packed {
        logic             func;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } jdz_item_t;

    typedef struct packed {
        jdz_item_t        item;
        logic [LEN_W-1:0] len;
        logic             dead;
        logic             zero;
    } jdz_tag_t;

    // Clamps a magnitude to the largest Q value and applies the sign.
    function automatic logic [Q_W-1:0] jdz_encode(input logic neg, input logic [Q_W-1:0] mag);
        logic [Q_W-1:0] m;
        m = (mag > Q_MAX) ? Q_MAX : mag;
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage

// ===== design/jdz_front.sv =====
// ----------------------------------------------------------------------------
// jdz_front
// Splits the raw readings into sign and magnitude, squares the
// magnitudes and sums the squares over two register stages.
// ----------------------------------------------------------------------------
module jdz_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            in_func,
    input  logic [jdz_pkg::AXIS_BITS-1:0]   in_x,
    input  logic [jdz_pkg::AXIS_BITS-1:0]   in_y,
    output logic                            out_valid,
    output jdz_pkg::jdz_item_t              out_item,
    output logic [jdz_pkg::SQ_W-1:0]        out_sum
);

    logic                        v1_reg, v1_next;
    logic                        v2_reg, v2_next;
    jdz_pkg::jdz_item_t          item1_reg, item1_next;
    jdz_pkg::jdz_item_t          item2_reg, item2_next;
    logic [jdz_pkg::SQ_W-1:0]    sqx_reg, sqx_next;
    logic [jdz_pkg::SQ_W-1:0]    sqy_reg, sqy_next;
    logic [jdz_pkg::SQ_W-1:0]    sum_reg, sum_next;

    always_comb begin
        item1_next.func  = in_func;
        item1_next.neg_x = in_x[jdz_pkg::AXIS_BITS-1];
        item1_next.neg_y = in_y[jdz_pkg::AXIS_BITS-1];
        item1_next.mag_x = in_x[jdz_pkg::AXIS_BITS-1] ? (~in_x + 1'b1) : in_x;
        item1_next.mag_y = in_y[jdz_pkg::AXIS_BITS-1] ? (~in_y + 1'b1) : in_y;
        sqx_next = jdz_pkg::SQ_W'(item1_next.mag_x) * jdz_pkg::SQ_W'(item1_next.mag_x);
        sqy_next = jdz_pkg::SQ_W'(item1_next.mag_y) * jdz_pkg::SQ_W'(item1_next.mag_y);
        v1_next    = in_valid;
        v2_next    = v1_reg;
        item2_next = item1_reg;
        sum_next   = sqx_reg + sqy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg <= item1_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            item2_reg <= item2_next;
            sum_reg   <= sum_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_sum   = sum_reg;

endmodule

// ===== design/jdz_sqrt.sv =====
// ----------------------------------------------------------------------------
// jdz_sqrt
// Pipelined restoring square root of the summed squares scaled by 2^16,
// one result bit per stage, giving the length with eight fraction bits.
// ----------------------------------------------------------------------------
module jdz_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  jdz_pkg::jdz_item_t           in_item,
    input  logic [jdz_pkg::SQ_W-1:0]     in_sum,
    output logic                         out_valid,
    output jdz_pkg::jdz_item_t           out_item,
    output logic [jdz_pkg::LEN_W-1:0]    out_len
);

    localparam int N = jdz_pkg::LEN_W;

    logic [N-1:0]                  valid_reg, valid_next;
    jdz_pkg::jdz_item_t            item_reg [N];
    jdz_pkg::jdz_item_t            item_next [N];
    logic [jdz_pkg::REM_W-1:0]     rem_reg [N];
    logic [jdz_pkg::REM_W-1:0]     rem_next [N];
    logic [jdz_pkg::LEN_W-1:0]     root_reg [N];
    logic [jdz_pkg::LEN_W-1:0]     root_next [N];
    logic [jdz_pkg::RAD_W-1:0]     rad_reg [N];
    logic [jdz_pkg::RAD_W-1:0]     rad_next [N];

    always_comb begin
        logic [jdz_pkg::REM_W-1:0] rem_in;
        logic [jdz_pkg::LEN_W-1:0] root_in;
        logic [jdz_pkg::RAD_W-1:0] rad_in;
        logic [jdz_pkg::REM_W-1:0] t;
        logic [jdz_pkg::REM_W-1:0] trial;
        logic                      ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rem_in        = '0;
                root_in       = '0;
                rad_in        = {in_sum, {(2 * jdz_pkg::LEN_FRAC){1'b0}}};
                item_next[k]  = in_item;
                valid_next[k] = in_valid;
            end else begin
                rem_in        = rem_reg[k-1];
                root_in       = root_reg[k-1];
                rad_in        = rad_reg[k-1];
                item_next[k]  = item_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            t            = {rem_in[jdz_pkg::REM_W-3:0], rad_in[jdz_pkg::RAD_W-1 -: 2]};
            trial        = jdz_pkg::REM_W'({root_in, 2'b01});
            ge           = (t >= trial);
            rem_next[k]  = ge ? (t - trial) : t;
            root_next[k] = {root_in[jdz_pkg::LEN_W-2:0], ge};
            rad_next[k]  = rad_in << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_item  = item_reg[N-1];
    assign out_len   = root_reg[N-1];

endmodule

// ===== design/jdz_scale.sv =====
// ----------------------------------------------------------------------------
// jdz_scale
// Applies the axial or radial dead zone and divides the distance past it
// by the live range, one quotient bit per stage, giving the deflection.
// ----------------------------------------------------------------------------
module jdz_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  jdz_pkg::jdz_item_t           in_item,
    input  logic [jdz_pkg::LEN_W-1:0]    in_len,
    input  logic [jdz_pkg::CFG_W-1:0]    dz_axis,
    input  logic [jdz_pkg::CFG_W-1:0]    dz_stick,
    input  logic [jdz_pkg::CFG_W-1:0]    full_scale,
    output logic                         out_valid,
    output jdz_pkg::jdz_tag_t            out_tag,
    output logic [jdz_pkg::Q_W-1:0]      out_fq
);

    localparam int N = jdz_pkg::FQ_STEPS;

    logic                                sv_reg, sv_next;
    jdz_pkg::jdz_tag_t                   stag_reg, stag_next;
    logic [jdz_pkg::LEN_W-1:0]           snum_reg, snum_next;
    logic [jdz_pkg::LEN_W-1:0]           sden_reg, sden_next;
    logic                                ssat_reg, ssat_next;

    logic [N-1:0]                        valid_reg, valid_next;
    logic [N-1:0]                        sat_reg, sat_next;
    jdz_pkg::jdz_tag_t                   tag_reg [N];
    jdz_pkg::jdz_tag_t                   tag_next [N];
    logic [jdz_pkg::LEN_W-1:0]           rem_reg [N];
    logic [jdz_pkg::LEN_W-1:0]           rem_next [N];
    logic [jdz_pkg::LEN_W-1:0]           den_reg [N];
    logic [jdz_pkg::LEN_W-1:0]           den_next [N];
    logic [jdz_pkg::OUT_FRAC_BITS-1:0]   q_reg [N];
    logic [jdz_pkg::OUT_FRAC_BITS-1:0]   q_next [N];

    always_comb begin
        logic [jdz_pkg::LEN_W-1:0] mag_w;
        logic [jdz_pkg::LEN_W-1:0] dza_w;
        logic [jdz_pkg::LEN_W-1:0] fs_w;
        logic [jdz_pkg::LEN_W-1:0] dzs8;
        logic                      fs_le;
        mag_w = jdz_pkg::LEN_W'(in_item.mag_x);
        dza_w = jdz_pkg::LEN_W'(dz_axis);
        fs_w  = jdz_pkg::LEN_W'(full_scale);
        dzs8  = jdz_pkg::LEN_W'({dz_stick, {jdz_pkg::LEN_FRAC{1'b0}}});
        stag_next.item = in_item;
        stag_next.len  = in_len;
        if (in_item.func) begin
            stag_next.dead = (in_len < dzs8);
            stag_next.zero = (in_len == '0);
            snum_next      = in_len - dzs8;
            sden_next      = jdz_pkg::LEN_W'({full_scale - dz_stick,
                                              {jdz_pkg::LEN_FRAC{1'b0}}});
            fs_le          = (full_scale <= dz_stick);
        end else begin
            stag_next.dead = (mag_w <= dza_w);
            stag_next.zero = 1'b0;
            snum_next      = mag_w - dza_w;
            sden_next      = fs_w - dza_w;
            fs_le          = (full_scale <= dz_axis);
        end
        ssat_next = fs_le || (snum_next >= sden_next);
        sv_next   = in_valid;
    end

    always_comb begin
        logic [jdz_pkg::LEN_W-1:0]         rem_in;
        logic [jdz_pkg::OUT_FRAC_BITS-1:0] q_in;
        logic [jdz_pkg::LEN_W:0]           t;
        logic                              ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rem_in        = snum_reg;
                q_in          = '0;
                den_next[k]   = sden_reg;
                sat_next[k]   = ssat_reg;
                tag_next[k]   = stag_reg;
                valid_next[k] = sv_reg;
            end else begin
                rem_in        = rem_reg[k-1];
                q_in          = q_reg[k-1];
                den_next[k]   = den_reg[k-1];
                sat_next[k]   = sat_reg[k-1];
                tag_next[k]   = tag_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            t           = {rem_in, 1'b0};
            ge          = (t >= {1'b0, den_next[k]});
            rem_next[k] = ge ? jdz_pkg::LEN_W'(t - {1'b0, den_next[k]})
                             : t[jdz_pkg::LEN_W-1:0];
            q_next[k]   = {q_in[jdz_pkg::OUT_FRAC_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg    <= 1'b0;
            valid_reg <= '0;
        end else if (en) begin
            sv_reg    <= sv_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stag_reg <= stag_next;
            snum_reg <= snum_next;
            sden_reg <= sden_next;
            ssat_reg <= ssat_next;
            sat_reg  <= sat_next;
            tag_reg  <= tag_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_tag   = tag_reg[N-1];
    assign out_fq    = sat_reg[N-1] ? jdz_pkg::Q_ONE : {1'b0, q_reg[N-1]};

endmodule

// ===== design/jdz_comp.sv =====
// ----------------------------------------------------------------------------
// jdz_comp
// Multiplies each stick component by the deflection and divides by the
// length, one quotient bit per stage, for both components side by side.
// ----------------------------------------------------------------------------
module jdz_comp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  jdz_pkg::jdz_tag_t            in_tag,
    input  logic [jdz_pkg::Q_W-1:0]      in_fq,
    output logic                         out_valid,
    output jdz_pkg::jdz_tag_t            out_tag,
    output logic [jdz_pkg::Q_W-1:0]      out_fq,
    output logic [jdz_pkg::Q_W-1:0]      out_qx,
    output logic [jdz_pkg::Q_W-1:0]      out_qy
);

    localparam int N = jdz_pkg::Q_W;

    logic                          mv_reg, mv_next;
    jdz_pkg::jdz_tag_t             mtag_reg, mtag_next;
    logic [jdz_pkg::Q_W-1:0]       mfq_reg, mfq_next;
    logic [jdz_pkg::PROD_W-1:0]    px_reg, px_next;
    logic [jdz_pkg::PROD_W-1:0]    py_reg, py_next;

    logic [N-1:0]                  valid_reg, valid_next;
    jdz_pkg::jdz_tag_t             tag_reg [N];
    jdz_pkg::jdz_tag_t             tag_next [N];
    logic [jdz_pkg::Q_W-1:0]       fq_reg [N];
    logic [jdz_pkg::Q_W-1:0]       fq_next [N];
    logic [jdz_pkg::LEN_W-1:0]     rx_reg [N];
    logic [jdz_pkg::LEN_W-1:0]     rx_next [N];
    logic [jdz_pkg::LEN_W-1:0]     ry_reg [N];
    logic [jdz_pkg::LEN_W-1:0]     ry_next [N];
    logic [jdz_pkg::Q_W-1:0]       lx_reg [N];
    logic [jdz_pkg::Q_W-1:0]       lx_next [N];
    logic [jdz_pkg::Q_W-1:0]       ly_reg [N];
    logic [jdz_pkg::Q_W-1:0]       ly_next [N];
    logic [jdz_pkg::Q_W-1:0]       qx_reg [N];
    logic [jdz_pkg::Q_W-1:0]       qx_next [N];
    logic [jdz_pkg::Q_W-1:0]       qy_reg [N];
    logic [jdz_pkg::Q_W-1:0]       qy_next [N];

    always_comb begin
        mv_next   = in_valid;
        mtag_next = in_tag;
        mfq_next  = in_fq;
        px_next   = jdz_pkg::PROD_W'(in_tag.item.mag_x) * jdz_pkg::PROD_W'(in_fq);
        py_next   = jdz_pkg::PROD_W'(in_tag.item.mag_y) * jdz_pkg::PROD_W'(in_fq);
    end

    always_comb begin
        logic [jdz_pkg::NUM_W-1:0] nx;
        logic [jdz_pkg::NUM_W-1:0] ny;
        logic [jdz_pkg::LEN_W-1:0] rx_in;
        logic [jdz_pkg::LEN_W-1:0] ry_in;
        logic [jdz_pkg::Q_W-1:0]   lx_in;
        logic [jdz_pkg::Q_W-1:0]   ly_in;
        logic [jdz_pkg::Q_W-1:0]   qx_in;
        logic [jdz_pkg::Q_W-1:0]   qy_in;
        logic [jdz_pkg::LEN_W:0]   tx;
        logic [jdz_pkg::LEN_W:0]   ty;
        logic [jdz_pkg::LEN_W:0]   len_w;
        logic                      gx;
        logic                      gy;
        nx = {px_reg, {jdz_pkg::LEN_FRAC{1'b0}}};
        ny = {py_reg, {jdz_pkg::LEN_FRAC{1'b0}}};
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rx_in         = nx[jdz_pkg::NUM_W-1:jdz_pkg::Q_W];
                ry_in         = ny[jdz_pkg::NUM_W-1:jdz_pkg::Q_W];
                lx_in         = nx[jdz_pkg::Q_W-1:0];
                ly_in         = ny[jdz_pkg::Q_W-1:0];
                qx_in         = '0;
                qy_in         = '0;
                tag_next[k]   = mtag_reg;
                fq_next[k]    = mfq_reg;
                valid_next[k] = mv_reg;
            end else begin
                rx_in         = rx_reg[k-1];
                ry_in         = ry_reg[k-1];
                lx_in         = lx_reg[k-1];
                ly_in         = ly_reg[k-1];
                qx_in         = qx_reg[k-1];
                qy_in         = qy_reg[k-1];
                tag_next[k]   = tag_reg[k-1];
                fq_next[k]    = fq_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            len_w      = {1'b0, tag_next[k].len};
            tx         = {rx_in, lx_in[jdz_pkg::Q_W-1]};
            ty         = {ry_in, ly_in[jdz_pkg::Q_W-1]};
            gx         = (tx >= len_w);
            gy         = (ty >= len_w);
            rx_next[k] = gx ? jdz_pkg::LEN_W'(tx - len_w) : tx[jdz_pkg::LEN_W-1:0];
            ry_next[k] = gy ? jdz_pkg::LEN_W'(ty - len_w) : ty[jdz_pkg::LEN_W-1:0];
            lx_next[k] = lx_in << 1;
            ly_next[k] = ly_in << 1;
            qx_next[k] = {qx_in[jdz_pkg::Q_W-2:0], gx};
            qy_next[k] = {qy_in[jdz_pkg::Q_W-2:0], gy};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg    <= 1'b0;
            valid_reg <= '0;
        end else if (en) begin
            mv_reg    <= mv_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mtag_reg <= mtag_next;
            mfq_reg  <= mfq_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            tag_reg  <= tag_next;
            fq_reg   <= fq_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_tag   = tag_reg[N-1];
    assign out_fq    = fq_reg[N-1];
    assign out_qx    = qx_reg[N-1];
    assign out_qy    = qy_reg[N-1];

endmodule

// ===== design/joystick_dead_zone_filter.sv =====
// ----------------------------------------------------------------------------
// joystick_dead_zone_filter: trigger and stick dead-zone conditioning, Q1.15.
// One request is accepted every cycle while no result waits on m_ready, and
// the whole pipeline holds while a result waits.
// Reset clears all stage valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module joystick_dead_zone_filter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic signed [jdz_pkg::AXIS_BITS-1:0] s_axis_x,
    input  logic signed [jdz_pkg::AXIS_BITS-1:0] s_axis_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [jdz_pkg::Q_W-1:0]       m_out_x,
    output logic signed [jdz_pkg::Q_W-1:0]       m_out_y,
    output logic                                 m_in_dead_zone,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jdz_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [jdz_pkg::CFG_W-1:0]            cfg_data
);

    logic                          en;
    logic [jdz_pkg::CFG_W-1:0]     dza_reg, dza_next;
    logic [jdz_pkg::CFG_W-1:0]     dzs_reg, dzs_next;
    logic [jdz_pkg::CFG_W-1:0]     fs_reg, fs_next;

    logic                          f_valid;
    jdz_pkg::jdz_item_t            f_item;
    logic [jdz_pkg::SQ_W-1:0]      f_sum;
    logic                          r_valid;
    jdz_pkg::jdz_item_t            r_item;
    logic [jdz_pkg::LEN_W-1:0]     r_len;
    logic                          d_valid;
    jdz_pkg::jdz_tag_t             d_tag;
    logic [jdz_pkg::Q_W-1:0]       d_fq;
    logic                          c_valid;
    jdz_pkg::jdz_tag_t             c_tag;
    logic [jdz_pkg::Q_W-1:0]       c_fq;
    logic [jdz_pkg::Q_W-1:0]       c_qx;
    logic [jdz_pkg::Q_W-1:0]       c_qy;

    logic                          ov_reg, ov_next;
    logic [jdz_pkg::Q_W-1:0]       ox_reg, ox_next;
    logic [jdz_pkg::Q_W-1:0]       oy_reg, oy_next;
    logic                          odz_reg, odz_next;

    assign en        = !ov_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        dza_next = dza_reg;
        dzs_next = dzs_reg;
        fs_next  = fs_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                jdz_pkg::CFG_DZ_AXIS:    dza_next = cfg_data;
                jdz_pkg::CFG_DZ_STICK:   dzs_next = cfg_data;
                jdz_pkg::CFG_FULL_SCALE: fs_next  = cfg_data;
                default: begin
                    dza_next = dza_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dza_reg <= jdz_pkg::DZ_AXIS_RST;
            dzs_reg <= jdz_pkg::DZ_STICK_RST;
            fs_reg  <= jdz_pkg::FULL_SCALE_RST;
        end else begin
            dza_reg <= dza_next;
            dzs_reg <= dzs_next;
            fs_reg  <= fs_next;
        end
    end

    jdz_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_func   (s_func),
        .in_x      (s_axis_x),
        .in_y      (s_axis_y),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_sum   (f_sum)
    );

    jdz_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_sum    (f_sum),
        .out_valid (r_valid),
        .out_item  (r_item),
        .out_len   (r_len)
    );

    jdz_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (r_valid),
        .in_item    (r_item),
        .in_len     (r_len),
        .dz_axis    (dza_reg),
        .dz_stick   (dzs_reg),
        .full_scale (fs_reg),
        .out_valid  (d_valid),
        .out_tag    (d_tag),
        .out_fq     (d_fq)
    );

    jdz_comp u_comp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_tag    (d_tag),
        .in_fq     (d_fq),
        .out_valid (c_valid),
        .out_tag   (c_tag),
        .out_fq    (c_fq),
        .out_qx    (c_qx),
        .out_qy    (c_qy)
    );

    always_comb begin
        ov_next  = c_valid;
        odz_next = c_tag.dead;
        ox_next  = '0;
        oy_next  = '0;
        if (!c_tag.dead && !c_tag.zero) begin
            if (c_tag.item.func) begin
                ox_next = jdz_pkg::jdz_encode(c_tag.item.neg_x, c_qx);
                oy_next = jdz_pkg::jdz_encode(c_tag.item.neg_y, c_qy);
            end else begin
                ox_next = jdz_pkg::jdz_encode(c_tag.item.neg_x, c_fq);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            odz_reg <= odz_next;
        end
    end

    assign m_valid        = ov_reg;
    assign m_out_x        = ox_reg;
    assign m_out_y        = oy_reg;
    assign m_in_dead_zone = odz_reg;

endmodule

// ===== design/jdz_checker.sv =====
// ----------------------------------------------------------------------------
// jdz_checker
// Port-level checks of the joystick dead-zone filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "joystick_dead_zone_filter_assert.svh"

module jdz_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [jdz_pkg::Q_W-1:0]       m_out_x,
    input logic signed [jdz_pkg::Q_W-1:0]       m_out_y,
    input logic                                 m_in_dead_zone
);

    `JDZ_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_out_x) && $stable(m_out_y))
    `JDZ_ASSERT_NOW(a_dead_zone_zero, m_valid && m_in_dead_zone, m_out_x == 0 && m_out_y == 0)
    `JDZ_ASSERT_NOW(a_no_min_code, m_valid, m_out_x != -32768 && m_out_y != -32768)
    `JDZ_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

endmodule

bind joystick_dead_zone_filter jdz_checker u_jdz_checker (.*);
